>>> rtl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AGE_W       = IDX_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam int                CAP_W     = 5;
  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam int                CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } lkvc_req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } lkvc_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             full;
    logic [IDX_W-1:0] victim_idx;
    logic [IDX_W-1:0] free_idx;
  } lkvc_look_t;

endpackage

>>> rtl/lkvc_lookup.sv
module lkvc_lookup (
  input  logic [lkvc_pkg::MAX_ENTRIES-1:0]   valid_i,
  input  logic [lkvc_pkg::KEY_W-1:0]         key_i [lkvc_pkg::MAX_ENTRIES],
  input  logic [lkvc_pkg::AGE_W-1:0]         age_i [lkvc_pkg::MAX_ENTRIES],
  input  logic [lkvc_pkg::CNT_W-1:0]         count_i,
  input  logic [lkvc_pkg::CAP_W-1:0]         cap_i,
  input  logic [lkvc_pkg::KEY_W-1:0]         req_key_i,
  output lkvc_pkg::lkvc_look_t               look_o
);
  import lkvc_pkg::*;

  logic [CMP_W-1:0] cap_ext;
  logic [CNT_W-1:0] eff_cap;
  logic [AGE_W-1:0] last_age;

  always_comb begin
    cap_ext = CMP_W'(cap_i);
    if (cap_i == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_ext);
    end
  end

  // oldest entry holds rank count-1
  assign last_age = AGE_W'(count_i - CNT_W'(1));

  always_comb begin
    look_o = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_i[i] && (key_i[i] == req_key_i)) begin
        look_o.hit     = 1'b1;
        look_o.hit_idx = IDX_W'(i);
      end
      if (!valid_i[i]) begin
        look_o.free_idx = IDX_W'(i);
      end
      if (valid_i[i] && (age_i[i] == last_age)) begin
        look_o.victim_idx = IDX_W'(i);
      end
    end
    look_o.full = (count_i >= eff_cap);
  end

endmodule

>>> rtl/lkvc_store.sv
module lkvc_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  lkvc_pkg::lkvc_req_t        req_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cap_i,
  output lkvc_pkg::lkvc_rsp_t        rsp_o
);
  import lkvc_pkg::*;

  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [AGE_W-1:0]       age_q [MAX_ENTRIES];
  logic [AGE_W-1:0]       age_d [MAX_ENTRIES];
  logic [KEY_W-1:0]       key_q [MAX_ENTRIES];
  logic [VAL_W-1:0]       val_q [MAX_ENTRIES];
  logic [CNT_W-1:0]       count_q, count_d;

  lkvc_look_t       look;
  logic             is_put;
  logic             touch;
  logic             insert;
  logic [IDX_W-1:0] slot;
  logic [AGE_W-1:0] thr;
  logic             write_key;
  logic             write_val;

  lkvc_lookup u_lookup (
    .valid_i   (valid_q),
    .key_i     (key_q),
    .age_i     (age_q),
    .count_i   (count_q),
    .cap_i     (cap_i),
    .req_key_i (req_i.key),
    .look_o    (look)
  );

  assign is_put    = (req_i.action == ACT_PUT);
  assign touch     = look.hit || (is_put && look.full);
  assign insert    = !look.hit && is_put && !look.full;
  assign slot      = look.hit ? look.hit_idx : (look.full ? look.victim_idx : look.free_idx);
  assign thr       = look.hit ? age_q[look.hit_idx] : age_q[look.victim_idx];
  assign write_key = fire_i && is_put && !look.hit;
  assign write_val = fire_i && is_put;

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      age_d[i] = age_q[i];
    end
    if (fire_i) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (touch) begin
          if (IDX_W'(i) == slot) begin
            age_d[i] = '0;
          end else if (valid_q[i] && (age_q[i] < thr)) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end else if (insert) begin
          if (IDX_W'(i) == slot) begin
            valid_d[i] = 1'b1;
            age_d[i]   = '0;
          end else if (valid_q[i]) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end
      end
      if (insert) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_key) begin
      key_q[slot] <= req_i.key;
    end
    if (write_val) begin
      val_q[slot] <= req_i.value;
    end
  end

  assign rsp_o.found      = look.hit;
  assign rsp_o.read_value = (look.hit && !is_put) ? val_q[look.hit_idx] : '0;
  assign rsp_o.evicted    = !look.hit && is_put && look.full;

endmodule

>>> rtl/lru_key_value_cache_unit.sv
// LRU key-value cache: fully associative store of up to 16 entries with
// least-recently-used replacement. Each request is a get or a put and gives
// exactly one response. A request is taken into an input register; once the
// output register is free or being read, all entries are compared against its
// key in parallel, the recency ranks are updated and the response lands in the
// output register. One request is taken every cycle while the output is not
// stalled; the response passes through the input and output registers, with
// the parallel compare and rank update between them. Capacity is written over
// APB at address 0, legal 1..16 (0 acts as 1, larger values as 16); lowering
// it flushes nothing, later put misses just evict. The store is empty after reset.
module lru_key_value_cache_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [63:0]                       s_axis_tdata,  // key, value
  input  logic [0:0]                        s_axis_tuser,  // action
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // read_value
  output logic [1:0]                        m_axis_tuser,  // found, evicted
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lkvc_pkg::*;

  logic             req_vld_q;
  lkvc_req_t        req_q;
  logic             out_vld_q;
  lkvc_rsp_t        out_q;
  lkvc_rsp_t        rsp;
  logic [CAP_W-1:0] cap_q;
  logic             fire;
  logic             accept;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign fire          = req_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !req_vld_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        req_vld_q <= 1'b1;
      end else if (fire) begin
        req_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.action <= s_axis_tuser[0];
      req_q.key    <= s_axis_tdata[31:0];
      req_q.value  <= s_axis_tdata[63:32];
    end
    if (fire) begin
      out_q <= rsp;
    end
  end

  lkvc_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .cap_i  (cap_q),
    .rsp_o  (rsp)
  );

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_q.read_value;
  assign m_axis_tuser[0] = out_q.found;
  assign m_axis_tuser[1] = out_q.evicted;

endmodule

>>> rtl/lkvc_checker.sv
module lkvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled response changed");

  a_hit_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("response both found and evicted");

  a_value_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata != 32'd0) |-> m_axis_tuser[0])
    else $error("value returned without hit");

  a_cap_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2] ##1 psel && !pwrite && !paddr[2]
      |-> prdata == 32'($past(pwdata[4:0])))
    else $error("capacity readback mismatch");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);

>>> bench/lru_key_value_cache_unit_test.sv
module lru_key_value_cache_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_CAPACITY, 2'b00};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata;   // key, value
  logic [0:0]            s_axis_tuser;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;   // read_value
  logic [1:0]            m_axis_tuser;   // found, evicted
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // mirror of the cache contents
  bit               entry_live [MAX_ENTRIES];
  logic [KEY_W-1:0] entry_tag  [MAX_ENTRIES];
  logic [VAL_W-1:0] entry_data [MAX_ENTRIES];
  int unsigned      entry_rank [MAX_ENTRIES];
  int unsigned      live_count;
  logic [CAP_W-1:0] cap_reg;

  lkvc_rsp_t   awaited_rsp_q [$];
  lkvc_rsp_t   want_rsp;
  int          error_count;
  int          cycle_count;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          sink_hold_cycles;

  lru_key_value_cache_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_key_value_cache_unit_test: done, errors");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    if (error_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    error_count++;
  endfunction

  // slot s becomes most recent; younger live entries age by one
  function automatic void promote(input int s);
    int unsigned old_rank;
    old_rank = entry_rank[s];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (entry_live[i] && i != s && entry_rank[i] < old_rank) entry_rank[i]++;
    end
    entry_rank[s] = 0;
  endfunction

  function automatic lkvc_rsp_t cache_access(input logic act, input logic [KEY_W-1:0] k,
                                             input logic [VAL_W-1:0] v);
    lkvc_rsp_t   rsp;
    int          hit_slot;
    int          slot;
    int unsigned limit;
    rsp = '0;
    hit_slot = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_slot < 0 && entry_live[i] && entry_tag[i] == k) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      rsp.found = 1'b1;
      if (act == ACT_PUT) entry_data[hit_slot] = v;
      else rsp.read_value = entry_data[hit_slot];
      promote(hit_slot);
    end else if (act == ACT_PUT) begin
      if (cap_reg == 0) limit = 1;
      else if (cap_reg > MAX_ENTRIES) limit = MAX_ENTRIES;
      else limit = cap_reg;
      slot = -1;
      if (live_count >= limit) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (entry_live[i] && (slot < 0 || entry_rank[i] > entry_rank[slot])) slot = i;
        end
        rsp.evicted = 1'b1;
        promote(slot);
      end else begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (!entry_live[i] && slot < 0) slot = i;
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (entry_live[i]) entry_rank[i]++;
        end
        entry_live[slot] = 1'b1;
        entry_rank[slot] = 0;
        live_count++;
      end
      entry_tag[slot] = k;
      entry_data[slot] = v;
    end
    return rsp;
  endfunction

  // response side: ready pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_rsp_q.size() == 0) begin
        note_error("response with no request outstanding");
      end else begin
        want_rsp = awaited_rsp_q.pop_front();
        if (m_axis_tuser[0] !== want_rsp.found || m_axis_tdata !== want_rsp.read_value ||
            m_axis_tuser[1] !== want_rsp.evicted) begin
          note_error($sformatf({"mismatch: want found=%0b value=%0d evicted=%0b, ",
                                "got found=%0b value=%0d evicted=%0b"},
                               want_rsp.found, want_rsp.read_value, want_rsp.evicted,
                               m_axis_tuser[0], $signed(m_axis_tdata), m_axis_tuser[1]));
        end
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_request(input logic act, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {v, k};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_rsp_q.push_back(cache_access(act, k, v));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register write, then read back of the capacity register
  task automatic program_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr[2] == REG_CAPACITY) cap_reg = data[CAP_W-1:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CAPACITY_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(APB_DATA_W-CAP_W){1'b0}}, cap_reg})
      note_error($sformatf("capacity read back %0d, want %0d", prdata, cap_reg));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_basic_requests();
    send_request(ACT_GET, 32'h0000_0000, $urandom);
    send_request(ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(ACT_GET, 32'h8000_0000, $urandom);
    send_request(ACT_GET, 32'h7fff_ffff, $urandom);
    send_request(ACT_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(ACT_GET, 32'h0000_0000, $urandom);
    send_request(ACT_GET, 32'h0000_0001, $urandom);
    send_request(ACT_GET, 32'hffff_ffff, $urandom);
    wait_idle();
  endtask

  // write outside the register map must leave capacity at 16
  task automatic test_unmapped_register();
    program_reg(UNMAPPED_ADDR, 32'h0000_0001);
    send_request(ACT_PUT, 32'h0000_0002, 32'hcafe_0002);
    send_request(ACT_GET, 32'h0000_0002, $urandom);
    wait_idle();
  endtask

  task automatic test_capacity_limits();
    // shrink below the current fill: no flush, put misses evict
    program_reg(CAPACITY_ADDR, 32'h0000_0001);
    send_request(ACT_PUT, 32'h0000_0003, 32'h0000_0033);
    send_request(ACT_GET, 32'h0000_0003, $urandom);
    send_request(ACT_GET, 32'h0000_0002, $urandom);
    wait_idle();
    program_reg(CAPACITY_ADDR, 32'h0000_0000);
    send_request(ACT_PUT, 32'h0000_0004, 32'h0000_0044);
    send_request(ACT_GET, 32'h0000_0003, $urandom);
    wait_idle();
    // saturates to the full store
    program_reg(CAPACITY_ADDR, 32'hffff_ffff);
    for (int i = 0; i < 13; i++) send_request(ACT_PUT, 32'h0000_0100 + i, $urandom);
    send_request(ACT_GET, 32'h0000_0100, $urandom);
    wait_idle();
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                  input int pool_size);
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] k;
    logic             act;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    key_pool = {};
    for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
    for (int i = 0; i < n_items; i++) begin
      act = ($urandom_range(99) < 45) ? ACT_PUT : ACT_GET;
      if ($urandom_range(99) < 12) k = $urandom;
      else k = key_pool[$urandom_range(pool_size - 1)];
      send_request(act, k, $urandom);
    end
    wait_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    program_reg(CAPACITY_ADDR, {27'($urandom_range(32'h07ff_ffff)), 5'd16});
    run_random_phase(200, 0, 0, 20);
    program_reg(CAPACITY_ADDR, {27'($urandom_range(32'h07ff_ffff)), 5'd4});
    run_random_phase(150, 75, 0, 7);
    program_reg(CAPACITY_ADDR, {27'($urandom_range(32'h07ff_ffff)), 5'd16});
    run_random_phase(150, 0, 75, 24);
    program_reg(CAPACITY_ADDR, {27'($urandom_range(32'h07ff_ffff)), 5'd1});
    run_random_phase(100, 20, 20, 3);
    program_reg(CAPACITY_ADDR, {27'($urandom_range(32'h07ff_ffff)), 5'd31});
    run_random_phase(150, 20, 20, 22);
    program_reg(CAPACITY_ADDR, {27'($urandom_range(32'h07ff_ffff)), 5'd9});
    run_random_phase(100, 0, 0, 13);
  endtask

  // long receiver hold-off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    program_reg(CAPACITY_ADDR, 32'h0000_0008);
    @(posedge clk_i);
    sink_hold_cycles = 200;
    @(negedge clk_i);
    run_random_phase(60, 0, 0, 12);
  endtask

  initial begin
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = '0;
    m_axis_tready    = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cap_reg          = CAP_RESET;
    live_count       = 0;
    error_count      = 0;
    cycle_count      = 0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    sink_hold_cycles = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      entry_live[i] = 1'b0;
      entry_rank[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_requests();
    test_unmapped_register();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (awaited_rsp_q.size() != 0) note_error("responses still outstanding at the end");
    if (error_count == 0) begin
      $display("lru_key_value_cache_unit_test: done, clean");
    end else begin
      $display("lru_key_value_cache_unit_test: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lkvc_pkg.sv
rtl/lkvc_lookup.sv
rtl/lkvc_store.sv
rtl/lru_key_value_cache_unit.sv
rtl/lkvc_checker.sv
bench/lru_key_value_cache_unit_test.sv
